// ===== sv/audio_fir_lowpass_17tap_assert.svh =====
// assertion macros shared by the fir filter rtl
`ifndef AUDIO_FIR_LOWPASS_17TAP_ASSERT_SVH
`define AUDIO_FIR_LOWPASS_17TAP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked property, muted while reset is asserted
`define AFL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked property, live during reset too
`define AFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AFL_ASSERT(lbl, clk, rstn, prop, msg)
`define AFL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/afl_pkg.sv =====
// types, constants and coefficient function of the low-pass fir filter
package afl_pkg;

    localparam int CFG_ADDR_BITS  = 3;
    localparam int BLOCK_LEN_BITS = 9;
    localparam int POS_BITS       = 8;

    // register index codes, taken from paddr[2]
    localparam logic REG_RESTART      = 1'b0;
    localparam logic REG_BLOCK_LENGTH = 1'b1;

    localparam logic                      RESTART_RESET   = 1'b1;
    localparam logic [BLOCK_LEN_BITS-1:0] BLOCK_LEN_RESET = 9'd96;
    localparam logic [BLOCK_LEN_BITS-1:0] MAX_BLOCK_LEN   = 9'd256;
    localparam logic [BLOCK_LEN_BITS-1:0] MIN_BLOCK_LEN   = 9'd1;

    // products summed per first-level adder group
    localparam int GROUP = 8;

    localparam int TABLE_LEN  = 17;
    localparam int TABLE_FRAC = 15;

    localparam int COEF_Q15 [TABLE_LEN] = '{
        -72, 758, 1127, 1770, 2494, 3202, 3799, 4198, 4338,
        4198, 3799, 3202, 2494, 1770, 1127, 758, -72
    };

    typedef struct packed {
        logic                      restart_each_block;
        logic [BLOCK_LEN_BITS-1:0] block_length;
    } cfg_t;

    // tap coefficient at the requested fraction width
    // below q15 it rounds to nearest, ties toward +inf
    function automatic int afl_coef(input int k, input int frac);
        int c;
        int s;
        if (k < 0 || k >= TABLE_LEN) begin
            return 0;
        end
        c = COEF_Q15[k];
        if (frac >= TABLE_FRAC) begin
            return c <<< (frac - TABLE_FRAC);
        end
        s = TABLE_FRAC - frac;
        return (c + (1 <<< (s - 1))) >>> s;
    endfunction

endpackage

// ===== sv/audio_fir_lowpass_17tap.sv =====
// top level of the symmetric 17-tap low-pass fir filter for audio samples
//
// input channel s_*: one unsigned sample per transfer on s_sample_in
// result channel m_*: m_filtered_out is the filter sum truncated toward zero,
//   modulo 2^SAMPLE_BITS; m_wrapped flags sums that fell outside that range
// apb port: register 0 restart_each_block, register 4 block_length (1..256)
// throughput: one sample per clock cycle while not stalled, no bubbles
//   between transfers; a result passes the window register, product
//   register, group sums, full sum and output register to m_valid
// stall: the whole five-stage pipeline holds while the output register is
//   full and m_ready is low; s_ready drops in exactly those cycles
// reset: history zero, block position zero, restart_each_block = 1,
//   block_length = 96, pipeline empty; no clearing pass, ready at once
// with restart_each_block set the history is cleared before the first
//   sample of every block, so each block is filtered from silence
module audio_fir_lowpass_17tap #(
    parameter int TAPS           = 17,
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [afl_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // sample input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [SAMPLE_BITS-1:0]             s_sample_in,
    // filtered output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [SAMPLE_BITS-1:0]             m_filtered_out,
    output logic                               m_wrapped
);
    import afl_pkg::*;

    localparam int CW = COEF_FRAC_BITS + 1;
    localparam int PW = SAMPLE_BITS + 1 + CW;
    localparam int AW = PW + $clog2(TAPS) + 1;

    // adding this to a negative sum before the shift truncates toward zero
    localparam logic signed [AW-1:0] TRUNC_BIAS = AW'((1 << COEF_FRAC_BITS) - 1);

    cfg_t                             cfg;
    logic                             advance;
    logic                             accept;
    logic                             win_valid;
    logic [TAPS-1:0][SAMPLE_BITS-1:0] window;
    logic                             acc_valid;
    logic signed [AW-1:0]             acc;
    logic signed [AW-1:0]             acc_adj;
    logic signed [AW-1:0]             quot;

    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] filtered_reg;
    logic [SAMPLE_BITS-1:0] filtered_next;
    logic                   wrapped_reg;
    logic                   wrapped_next;

    // the pipeline moves whenever the output register can take a result
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    afl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    afl_window #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .accept    (accept),
        .advance   (advance),
        .sample    (s_sample_in),
        .win_valid (win_valid),
        .window    (window)
    );

    afl_mac #(
        .TAPS           (TAPS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .win_valid (win_valid),
        .window    (window),
        .acc_valid (acc_valid),
        .acc       (acc)
    );

    // truncate toward zero, then wrap to the sample width
    assign acc_adj       = acc[AW-1] ? (acc + TRUNC_BIAS) : acc;
    assign quot          = acc_adj >>> COEF_FRAC_BITS;
    assign filtered_next = quot[SAMPLE_BITS-1:0];
    // any set bit above the sample width means the value was out of range
    assign wrapped_next  = (quot[AW-1:SAMPLE_BITS] != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= acc_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            filtered_reg <= filtered_next;
            wrapped_reg  <= wrapped_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_filtered_out = filtered_reg;
    assign m_wrapped      = wrapped_reg;

    `AFL_ASSERT(a_result_has_source, aclk, aresetn, $rose(m_valid_reg) |-> $past(acc_valid), "result appeared with no sum in flight")
    `AFL_ASSERT(a_sum_reaches_output, aclk, aresetn, acc_valid && advance |=> m_valid_reg, "finished sum was dropped")
    `AFL_ASSERT_ALWAYS(a_reset_empties_output, aclk, !aresetn |=> !m_valid_reg, "output valid after reset")

endmodule

// ===== sv/afl_regs.sv =====
// apb configuration registers of the fir filter
module afl_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [afl_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output afl_pkg::cfg_t                      cfg
);
    import afl_pkg::*;

    logic                      restart_reg;
    logic                      restart_next;
    logic [BLOCK_LEN_BITS-1:0] block_len_reg;
    logic [BLOCK_LEN_BITS-1:0] block_len_next;
    logic                      wr_en;
    logic                      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_comb begin
        restart_next   = restart_reg;
        block_len_next = block_len_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_RESTART:      restart_next   = pwdata[0];
                REG_BLOCK_LENGTH: block_len_next = pwdata[BLOCK_LEN_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            restart_reg   <= RESTART_RESET;
            block_len_reg <= BLOCK_LEN_RESET;
        end else begin
            restart_reg   <= restart_next;
            block_len_reg <= block_len_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RESTART:      prdata = {31'd0, restart_reg};
            REG_BLOCK_LENGTH: prdata = {{(32-BLOCK_LEN_BITS){1'b0}}, block_len_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.restart_each_block = restart_reg;
    assign cfg.block_length       = block_len_reg;

endmodule

// ===== sv/afl_window.sv =====
// sample history, block position and tap window register
`include "audio_fir_lowpass_17tap_assert.svh"
module afl_window #(
    parameter int TAPS        = 17,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  afl_pkg::cfg_t                       cfg,
    input  logic                                accept,
    input  logic                                advance,
    input  logic [SAMPLE_BITS-1:0]              sample,
    output logic                                win_valid,
    output logic [TAPS-1:0][SAMPLE_BITS-1:0]    window
);
    import afl_pkg::*;

    logic [TAPS-2:0][SAMPLE_BITS-1:0] hist_reg;
    logic [TAPS-2:0][SAMPLE_BITS-1:0] hist_next;
    logic [TAPS-2:0][SAMPLE_BITS-1:0] hist_eff;
    logic [TAPS-1:0][SAMPLE_BITS-1:0] window_reg;
    logic [TAPS-1:0][SAMPLE_BITS-1:0] window_next;
    logic                             win_valid_reg;
    logic [POS_BITS-1:0]              pos_reg;
    logic [POS_BITS-1:0]              pos_next;
    logic [POS_BITS-1:0]              pos_inc;
    logic [BLOCK_LEN_BITS-1:0]        eff_len;
    logic                             clear_hist;

    // zero length acts as one, anything past 256 as 256
    always_comb begin
        if (cfg.block_length == '0) begin
            eff_len = MIN_BLOCK_LEN;
        end else if (cfg.block_length > MAX_BLOCK_LEN) begin
            eff_len = MAX_BLOCK_LEN;
        end else begin
            eff_len = cfg.block_length;
        end
    end

    assign clear_hist  = cfg.restart_each_block && (pos_reg == '0);
    assign hist_eff    = clear_hist ? '0 : hist_reg;
    assign window_next = {hist_eff, sample};
    assign pos_inc     = pos_reg + 1'b1;

    always_comb begin
        hist_next = hist_reg;
        pos_next  = pos_reg;
        if (accept) begin
            hist_next = {hist_eff[TAPS-3:0], sample};
            if (pos_inc == '0 || {1'b0, pos_inc} >= eff_len) begin
                pos_next = '0;
            end else begin
                pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg      <= '0;
            pos_reg       <= '0;
            win_valid_reg <= 1'b0;
        end else begin
            hist_reg <= hist_next;
            pos_reg  <= pos_next;
            if (advance) begin
                win_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            window_reg <= window_next;
        end
    end

    assign win_valid = win_valid_reg;
    assign window    = window_reg;

    `AFL_ASSERT(a_clear_empties_history, aclk, aresetn, accept && clear_hist |=> hist_reg[TAPS-2] == '0, "history not cleared at block start")
    `AFL_ASSERT(a_idle_state_holds, aclk, aresetn, !accept |=> $stable(pos_reg) && $stable(hist_reg), "history or position moved without a transfer")

endmodule

// ===== sv/afl_mac.sv =====
// constant-coefficient products and two-level registered adder tree
module afl_mac #(
    parameter int TAPS           = 17,
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 15,
    localparam int CW            = COEF_FRAC_BITS + 1,
    localparam int PW            = SAMPLE_BITS + 1 + CW,
    localparam int AW            = PW + $clog2(TAPS) + 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             advance,
    input  logic                             win_valid,
    input  logic [TAPS-1:0][SAMPLE_BITS-1:0] window,
    output logic                             acc_valid,
    output logic signed [AW-1:0]             acc
);
    import afl_pkg::*;

    localparam int NGRP = (TAPS + GROUP - 1) / GROUP;
    localparam int PADN = NGRP * GROUP;

    logic signed [PW-1:0] prod_next [PADN];
    logic signed [PW-1:0] prod_reg  [PADN];
    logic signed [AW-1:0] grp_next  [NGRP];
    logic signed [AW-1:0] grp_reg   [NGRP];
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] acc_reg;
    logic                 prod_valid_reg;
    logic                 grp_valid_reg;
    logic                 acc_valid_reg;

    for (genvar k = 0; k < PADN; k++) begin : g_tap
        if (k < TAPS) begin : g_live
            localparam logic signed [CW-1:0] C = CW'(afl_coef(k, COEF_FRAC_BITS));
            logic signed [SAMPLE_BITS:0] xs;
            assign xs           = $signed({1'b0, window[k]});
            assign prod_next[k] = xs * C;
        end else begin : g_pad
            assign prod_next[k] = '0;
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                grp_next[g] = grp_next[g] + AW'(prod_reg[g*GROUP + j]);
            end
        end
    end

    always_comb begin
        acc_next = '0;
        for (int g = 0; g < NGRP; g++) begin
            acc_next = acc_next + grp_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            grp_valid_reg  <= 1'b0;
            acc_valid_reg  <= 1'b0;
        end else if (advance) begin
            prod_valid_reg <= win_valid;
            grp_valid_reg  <= prod_valid_reg;
            acc_valid_reg  <= grp_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= prod_next;
            grp_reg  <= grp_next;
            acc_reg  <= acc_next;
        end
    end

    assign acc_valid = acc_valid_reg;
    assign acc       = acc_reg;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the 17-tap low-pass fir filter
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import afl_pkg::*;

    localparam int TAPS        = 17;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_FRAC   = 15;
    localparam int RANDOM_ITEMS = 220;

    // one filter output as seen on the result channel
    typedef struct {
        logic [SAMPLE_BITS-1:0] level;
        logic                   wrapped;
    } fir_output_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [SAMPLE_BITS-1:0]   s_sample_in = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [SAMPLE_BITS-1:0]   m_filtered_out;
    logic                     m_wrapped;

    // filter state as the testbench tracks it
    logic [SAMPLE_BITS-1:0]    past_samples [TAPS-1];
    logic [7:0]                block_pos;
    logic                      cfg_restart;
    logic [BLOCK_LEN_BITS-1:0] cfg_block_len;

    fir_output_t expected_filtered [$];
    int          mismatch_count = 0;
    int          random_sent = 0;

    // traffic shaping knobs shared by the test tasks and the result sink
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_hold_left = 0;

    audio_fir_lowpass_17tap u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_in    (s_sample_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_filtered_out (m_filtered_out),
        .m_wrapped      (m_wrapped)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // q1.15 low-pass taps, mirrored around the center tap
    function automatic longint lowpass_coef(input int k);
        int m;
        m = (k > 8) ? 16 - k : k;
        case (m)
            0: return -72;
            1: return 758;
            2: return 1127;
            3: return 1770;
            4: return 2494;
            5: return 3202;
            6: return 3799;
            7: return 4198;
            default: return 4338;
        endcase
    endfunction

    // runs one accepted sample through the tracked filter and queues its output
    function automatic void filter_sample(input logic [SAMPLE_BITS-1:0] x);
        longint      acc;
        longint      q;
        int unsigned eff_len;
        fir_output_t res;
        // a new block starts from silence when restarting is enabled
        if (cfg_restart && block_pos == 0) begin
            for (int i = 0; i < TAPS - 1; i++) past_samples[i] = '0;
        end
        acc = lowpass_coef(0) * longint'({48'd0, x});
        for (int k = 1; k < TAPS; k++) begin
            acc += lowpass_coef(k) * longint'({48'd0, past_samples[k-1]});
        end
        // signed division truncates toward zero
        q = acc / (longint'(1) << COEF_FRAC);
        for (int k = TAPS - 2; k > 0; k--) past_samples[k] = past_samples[k-1];
        past_samples[0] = x;
        // zero length acts as one, lengths past 256 saturate
        eff_len = (cfg_block_len == 0) ? 1 :
                  (cfg_block_len > MAX_BLOCK_LEN) ? 256 : cfg_block_len;
        block_pos = block_pos + 8'd1;
        if (block_pos == 0 || block_pos >= eff_len) block_pos = '0;
        res.level   = q[SAMPLE_BITS-1:0];
        res.wrapped = (q < 0 || q > 65535);
        expected_filtered.push_back(res);
    endfunction

    // mostly full-range values, with extremes and small values mixed in
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return SAMPLE_BITS'($urandom_range(255));
            3: return SAMPLE_BITS'($urandom_range(65535, 65000));
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // offers one sample and returns just after the edge that takes it
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] x);
        if (!tx_steady && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        filter_sample(x);
    endtask

    // sender goes quiet until every queued output has come back
    task automatic wait_outputs_done();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_filtered.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // register takes the value at this edge
        if (idx == REG_RESTART) begin
            cfg_restart = value[0];
        end else begin
            cfg_block_len = value[BLOCK_LEN_BITS-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic idx, output logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // reads both registers back and compares them with the tracked setting
    task automatic check_registers();
        logic [31:0] rd;
        apb_read(REG_RESTART, rd);
        if (rd[0] !== cfg_restart) begin
            $display("%0t: restart_each_block read expected %0d actual %0d",
                     $realtime, cfg_restart, rd[0]);
            mismatch_count++;
        end
        apb_read(REG_BLOCK_LENGTH, rd);
        if (rd[BLOCK_LEN_BITS-1:0] !== cfg_block_len) begin
            $display("%0t: block_length read expected %0d actual %0d",
                     $realtime, cfg_block_len, rd[BLOCK_LEN_BITS-1:0]);
            mismatch_count++;
        end
    endtask

    // only called while idle; upper data bits carry junk the block must ignore
    task automatic set_config(input logic restart, input int unsigned len);
        wait_outputs_done();
        apb_write(REG_RESTART, {$urandom_range(1) ? 31'h7fff_fffe : 31'd0, restart});
        apb_write(REG_BLOCK_LENGTH,
                  {23'($urandom), len[BLOCK_LEN_BITS-1:0]});
        check_registers();
    endtask

    task automatic send_random_run(input int count);
        for (int i = 0; i < count; i++) send_sample(pick_sample());
    endtask

    // result sink: stalls at random, for a requested stretch of cycles, or not in steady mode
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else if (rx_steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 8);
        end
    end

    // compares each output transfer against the oldest queued prediction
    always @(posedge aclk) begin
        fir_output_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_filtered.size() == 0) begin
                $display("%0t: unexpected output, expected none actual %h/%b",
                         $realtime, m_filtered_out, m_wrapped);
                mismatch_count++;
            end else begin
                want = expected_filtered.pop_front();
                if (m_filtered_out !== want.level) begin
                    $display("%0t: filtered_out expected %h actual %h",
                             $realtime, want.level, m_filtered_out);
                    mismatch_count++;
                end
                if (m_wrapped !== want.wrapped) begin
                    $display("%0t: wrapped expected %b actual %b",
                             $realtime, want.wrapped, m_wrapped);
                    mismatch_count++;
                end
            end
        end
    end

    // registers come out of reset with restart on and 96-sample blocks
    task automatic test_reset_values();
        check_registers();
    endtask

    // extremes: lone full-scale sample wraps below zero, a full-scale run
    // overshoots and wraps above the range, alternating bit patterns
    task automatic test_directed_extremes();
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h5555);
        send_sample(16'haaaa);
        for (int i = 0; i < TAPS; i++) send_sample(16'hffff);
    endtask

    // block length limits, zero treated as one and oversize values saturated
    task automatic test_block_lengths();
        set_config(1'b1, MIN_BLOCK_LEN);
        send_random_run(12);
        set_config(1'b1, 0);
        send_random_run(12);
        set_config(1'b1, 2);
        send_random_run(20);
        set_config(1'b1, MAX_BLOCK_LEN);
        send_random_run(40);
        set_config(1'b1, 511);
        send_random_run(270);
    endtask

    // shrinking the length mid-block ends the block on the next sample
    task automatic test_length_change_midblock();
        set_config(1'b1, 96);
        send_random_run(50);
        set_config(1'b1, 10);
        send_random_run(30);
    endtask

    // continuous mode keeps the history across block boundaries
    task automatic test_continuous();
        set_config(1'b0, 8);
        send_random_run(40);
        set_config(1'b0, MAX_BLOCK_LEN);
        for (int i = 0; i < 30; i++) send_sample(16'hffff);
    endtask

    // sink holds off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        set_config(1'b1, 16);
        tx_steady = 1'b1;
        rx_hold_left = 80;
        send_random_run(40);
        tx_steady = 1'b0;
        wait_outputs_done();
    endtask

    // random phases of random settings, one of them with no idling at all
    task automatic test_random_phases();
        int          phase;
        int unsigned len;
        int          run;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(19))
                0:       len = 0;
                1:       len = MAX_BLOCK_LEN;
                2:       len = $urandom_range(511, 257);
                3, 4:    len = $urandom_range(255, 100);
                default: len = $urandom_range(24, 1);
            endcase
            set_config(1'($urandom_range(1)), len);
            run = $urandom_range(60, 10);
            tx_steady = (phase == 3);
            rx_steady = (phase == 3);
            if (phase == 3) run = 120;
            send_random_run(run);
            random_sent += run;
            phase++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < TAPS - 1; i++) past_samples[i] = '0;
        block_pos     = '0;
        cfg_restart   = RESTART_RESET;
        cfg_block_len = BLOCK_LEN_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_directed_extremes();
        test_block_lengths();
        test_length_change_midblock();
        test_continuous();
        test_backpressure();
        test_random_phases();

        // drain, then allow a few pipeline depths for stray outputs
        wait_outputs_done();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_filtered.size() == 0) begin
            $display("audio_fir_lowpass_17tap: match");
        end else begin
            $display("audio_fir_lowpass_17tap: mismatch");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("audio_fir_lowpass_17tap: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/afl_pkg.sv
sv/afl_regs.sv
sv/afl_window.sv
sv/afl_mac.sv
sv/audio_fir_lowpass_17tap.sv
tb/tb_top.sv
